// ----- hdl/npcc_pkg.sv -----
// npcc_pkg: shared constants and palette tables for the nearest palette
// colour classifier; no dependencies
package npcc_pkg;

  localparam int CH_W        = 8;   // width of one colour channel
  localparam int IDX_W       = 4;   // width of the colour index
  localparam int DIST_W      = 20;  // width of the weighted squared distance
  localparam int PAL_SLOTS   = 16;  // palette slots in the tables
  localparam int NUM_COLOURS = 9;   // default palette size

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  // weight offsets of the redmean formula
  localparam logic [9:0] RED_BIAS  = 10'd512;
  localparam logic [9:0] BLUE_BIAS = 10'd767;

  // palette: violet, purple, blue, green, yellow, orange, red, black, white,
  // then black for the unused slots
  localparam chan_t PAL_R [PAL_SLOTS] = '{
    8'd148, 8'd75, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam chan_t PAL_G [PAL_SLOTS] = '{
    8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd127, 8'd0, 8'd0, 8'd255,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam chan_t PAL_B [PAL_SLOTS] = '{
    8'd211, 8'd130, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a >= b) ? chan_t'(a - b) : chan_t'(b - a);
  endfunction

endpackage

// ----- hdl/nearest_palette_colour_classifier_core.sv -----
// nearest_palette_colour_classifier_core: redmean nearest palette colour search
// six-stage pipeline, one lane per palette entry; depends on npcc_pkg
//
// throughput: one word per cycle when the output side does not stall
// each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a waiting result blocks input only once all six stages are full
// reset (rst, synchronous) clears the valid bits only; data registers are not reset
module nearest_palette_colour_classifier_core #(
  parameter int PALETTE_SIZE = npcc_pkg::NUM_COLOURS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [npcc_pkg::CH_W-1:0]  red,
  input  logic [npcc_pkg::CH_W-1:0]  green,
  input  logic [npcc_pkg::CH_W-1:0]  blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [npcc_pkg::IDX_W-1:0] colour_index,
  output logic [npcc_pkg::DIST_W-1:0] distance_squared
);
  import npcc_pkg::*;

  localparam int N_LANES  = PALETTE_SIZE;
  localparam int GRP      = 4;                         // lanes per group in the min search
  localparam int N_GROUPS = (PALETTE_SIZE + GRP - 1) / GRP;
  localparam int N_STG    = 6;

  // stage valid bits and advance enables, stage k at bit k-1
  logic [N_STG-1:0] vld;
  logic [N_STG-1:0] adv;

  always_comb begin
    adv[N_STG-1] = !vld[N_STG-1] || out_ready;
    for (int k = N_STG-2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < N_STG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: channel differences and red mean per lane
  chan_t s1_rmean [N_LANES];
  chan_t s1_dr    [N_LANES];
  chan_t s1_dg    [N_LANES];
  chan_t s1_db    [N_LANES];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < N_LANES; k++) begin
        s1_rmean[k] <= chan_t'(({1'b0, red} + {1'b0, PAL_R[k]}) >> 1);
        s1_dr[k]    <= abs_diff(red, PAL_R[k]);
        s1_dg[k]    <= abs_diff(green, PAL_G[k]);
        s1_db[k]    <= abs_diff(blue, PAL_B[k]);
      end
    end
  end

  // stage 2: weight times difference, green square
  logic [17:0] s2_wr [N_LANES];
  logic [17:0] s2_wb [N_LANES];
  logic [15:0] s2_g2 [N_LANES];
  chan_t       s2_dr [N_LANES];
  chan_t       s2_db [N_LANES];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < N_LANES; k++) begin
        s2_wr[k] <= (RED_BIAS + 10'(s1_rmean[k])) * 18'(s1_dr[k]);
        s2_wb[k] <= (BLUE_BIAS - 10'(s1_rmean[k])) * 18'(s1_db[k]);
        s2_g2[k] <= 16'(s1_dg[k]) * 16'(s1_dg[k]);
        s2_dr[k] <= s1_dr[k];
        s2_db[k] <= s1_db[k];
      end
    end
  end

  // stage 3: second multiply and scale by 1/256, green square times 4
  logic [17:0] s3_tr [N_LANES];
  logic [17:0] s3_tb [N_LANES];
  logic [17:0] s3_tg [N_LANES];
  logic [25:0] prod_r [N_LANES];
  logic [25:0] prod_b [N_LANES];

  always_comb begin
    for (int k = 0; k < N_LANES; k++) begin
      prod_r[k] = 26'(s2_wr[k]) * 26'(s2_dr[k]);
      prod_b[k] = 26'(s2_wb[k]) * 26'(s2_db[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < N_LANES; k++) begin
        s3_tr[k] <= prod_r[k][25:8];
        s3_tb[k] <= prod_b[k][25:8];
        s3_tg[k] <= {s2_g2[k], 2'b00};
      end
    end
  end

  // stage 4: sum of the three terms, always below 2^20
  dist_t s4_dist [N_LANES];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < N_LANES; k++) begin
        s4_dist[k] <= DIST_W'(s3_tr[k]) + DIST_W'(s3_tg[k]) + DIST_W'(s3_tb[k]);
      end
    end
  end

  // stage 5: minimum within each group of four lanes, strict compare keeps
  // the lower index on a tie
  dist_t grp_d_next [N_GROUPS];
  idx_t  grp_i_next [N_GROUPS];
  dist_t s5_d [N_GROUPS];
  idx_t  s5_i [N_GROUPS];

  always_comb begin
    for (int g = 0; g < N_GROUPS; g++) begin
      grp_d_next[g] = s4_dist[g*GRP];
      grp_i_next[g] = IDX_W'(g*GRP);
      for (int j = 1; j < GRP; j++) begin
        if (g*GRP + j < N_LANES) begin
          if (s4_dist[g*GRP + j] < grp_d_next[g]) begin
            grp_d_next[g] = s4_dist[g*GRP + j];
            grp_i_next[g] = IDX_W'(g*GRP + j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int g = 0; g < N_GROUPS; g++) begin
        s5_d[g] <= grp_d_next[g];
        s5_i[g] <= grp_i_next[g];
      end
    end
  end

  // stage 6: minimum over the groups, in index order
  dist_t best_d_next;
  idx_t  best_i_next;

  always_comb begin
    best_d_next = s5_d[0];
    best_i_next = s5_i[0];
    for (int g = 1; g < N_GROUPS; g++) begin
      if (s5_d[g] < best_d_next) begin
        best_d_next = s5_d[g];
        best_i_next = s5_i[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      colour_index     <= best_i_next;
      distance_squared <= best_d_next;
    end
  end

  assign out_valid = vld[N_STG-1];

  // an empty output stage never blocks the input
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked while output stage empty");

  // the chosen entry is always one of the palette entries
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(colour_index) < PALETTE_SIZE))
    else $error("colour index beyond palette");

  // a word waiting behind a stalled output is kept
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && vld[N_STG-2]) |=> vld[N_STG-2])
    else $error("word lost behind stalled output");

  // after reset the pipeline is empty
  assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("valid bits not cleared by reset");

endmodule
